// File: src/pcc_pkg.sv
// Shared types, constants and functions for the clamped PID controller.
// Holds the microcode table, the saturation helpers and the register map.
// Used by every other file of the block; depends on nothing.
package pcc_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int SatBits = (SAMPLE_WIDTH < 16) ? 16 :
                            ((SAMPLE_WIDTH > 32) ? 32 : SAMPLE_WIDTH);
   localparam int DivSteps = 32;

   typedef logic signed [31:0] sample_type;
   typedef logic [30:0]        bound_type;
   typedef logic [31:0]        step_time_type;
   typedef logic signed [32:0] mul_type;
   typedef logic signed [33:0] acc_type;
   typedef logic signed [65:0] wide_type;
   typedef logic [4:0]         loop_cnt_type;
   typedef logic [2:0]         csr_addr_type;

   localparam wide_type SatHi = (wide_type'(1) <<< (SatBits - 1)) - wide_type'(1);
   localparam wide_type SatLo = -SatHi - wide_type'(1);
   localparam loop_cnt_type LoopLast = loop_cnt_type'(DivSteps - 1);

   typedef enum logic [2:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_INTEG_GAIN     = 3'd1,
      CSR_DERIV_GAIN     = 3'd2,
      CSR_INTEGRAL_BOUND = 3'd3,
      CSR_DRIVE_BOUND    = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_CLEAR, OP_ERR, OP_MUL_P, OP_ACC_P, OP_MUL_INC, OP_INC,
      OP_ADD_I, OP_CLAMP_I, OP_MUL_I, OP_ACC_I, OP_DIV_INIT, OP_DIV_STEP,
      OP_DIV_FIX, OP_MUL_D, OP_ACC_D, OP_DRIVE, OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      BR_NEXT, BR_JUMP, BR_DISPATCH, BR_LOOP, BR_WAIT
   } branch_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ERR, ST_MUL_P, ST_ACC_P, ST_MUL_INC, ST_INC, ST_ADD_I,
      ST_CLAMP_I, ST_MUL_I, ST_ACC_I, ST_DIV_INIT, ST_DIV_STEP, ST_DIV_FIX,
      ST_MUL_D, ST_ACC_D, ST_DRIVE, ST_DONE, ST_CLEAR
   } step_type;

   typedef struct packed {
      op_type     op;
      branch_type br;
      step_type   target;
   } ucode_type;

   function automatic ucode_type microcode(input step_type pc);
      ucode_type w;
      unique case (pc)
         ST_IDLE:     w = '{OP_LOAD,     BR_DISPATCH, ST_ERR};
         ST_ERR:      w = '{OP_ERR,      BR_NEXT,     ST_IDLE};
         ST_MUL_P:    w = '{OP_MUL_P,    BR_NEXT,     ST_IDLE};
         ST_ACC_P:    w = '{OP_ACC_P,    BR_NEXT,     ST_IDLE};
         ST_MUL_INC:  w = '{OP_MUL_INC,  BR_NEXT,     ST_IDLE};
         ST_INC:      w = '{OP_INC,      BR_NEXT,     ST_IDLE};
         ST_ADD_I:    w = '{OP_ADD_I,    BR_NEXT,     ST_IDLE};
         ST_CLAMP_I:  w = '{OP_CLAMP_I,  BR_NEXT,     ST_IDLE};
         ST_MUL_I:    w = '{OP_MUL_I,    BR_NEXT,     ST_IDLE};
         ST_ACC_I:    w = '{OP_ACC_I,    BR_NEXT,     ST_IDLE};
         ST_DIV_INIT: w = '{OP_DIV_INIT, BR_NEXT,     ST_IDLE};
         ST_DIV_STEP: w = '{OP_DIV_STEP, BR_LOOP,     ST_IDLE};
         ST_DIV_FIX:  w = '{OP_DIV_FIX,  BR_NEXT,     ST_IDLE};
         ST_MUL_D:    w = '{OP_MUL_D,    BR_NEXT,     ST_IDLE};
         ST_ACC_D:    w = '{OP_ACC_D,    BR_NEXT,     ST_IDLE};
         ST_DRIVE:    w = '{OP_DRIVE,    BR_NEXT,     ST_IDLE};
         ST_DONE:     w = '{OP_DONE,     BR_WAIT,     ST_IDLE};
         ST_CLEAR:    w = '{OP_CLEAR,    BR_JUMP,     ST_DONE};
         default:     w = '{OP_NOP,      BR_JUMP,     ST_IDLE};
      endcase
      return w;
   endfunction

   function automatic sample_type sat(input wide_type x);
      sample_type r;
      if (x > SatHi) begin
         r = SatHi[31:0];
      end else if (x < SatLo) begin
         r = SatLo[31:0];
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic sample_type clamp_mag(input sample_type x, input bound_type b);
      logic signed [32:0] xs;
      logic signed [32:0] bs;
      logic signed [32:0] nbs;
      sample_type r;
      xs  = {x[31], x};
      bs  = {2'b00, b};
      nbs = -bs;
      if (xs > bs) begin
         r = bs[31:0];
      end else if (xs < nbs) begin
         r = nbs[31:0];
      end else begin
         r = x;
      end
      return r;
   endfunction

endpackage

// File: src/pcc_channels.sv
// Handshake channels of the clamped PID controller: request and response words.
// Depends on pcc_pkg for the payload types.
interface pcc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   pcc_pkg::sample_type         target;
   pcc_pkg::sample_type         measured;
   pcc_pkg::step_time_type      step_time;

   modport source (output valid, action, target, measured, step_time, input ready);
   modport sink (input valid, action, target, measured, step_time, output ready);
endinterface

interface pcc_rsp_if;
   logic                valid;
   logic                ready;
   pcc_pkg::sample_type drive;
   pcc_pkg::sample_type integral_now;

   modport source (output valid, drive, integral_now, input ready);
   modport sink (input valid, drive, integral_now, output ready);
endinterface

// File: src/pcc_sequencer.sv
// Microcode sequencer: step counter, control store lookup, loop count and branching.
// Also owns the request handshake and the response valid flag. Depends on pcc_pkg.
module pcc_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   input  pcc_pkg::step_time_type req_step_time,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output pcc_pkg::op_type        op
);

   pcc_pkg::step_type     pc_ff;
   pcc_pkg::step_type     pc_in;
   pcc_pkg::loop_cnt_type cnt_ff;
   pcc_pkg::loop_cnt_type cnt_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   pcc_pkg::ucode_type    uword;
   logic                  accept;
   logic                  blocked;

   assign uword     = pcc_pkg::microcode(pc_ff);
   assign req_ready = (pc_ff == pcc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign blocked   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      op           = uword.op;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (uword.br)
         pcc_pkg::BR_NEXT: begin
            pc_in = pcc_pkg::step_type'(pc_ff + 5'd1);
         end
         pcc_pkg::BR_JUMP: begin
            pc_in = uword.target;
         end
         pcc_pkg::BR_DISPATCH: begin
            priority if (!accept) begin
               op = pcc_pkg::OP_NOP;
            end else if (req_action) begin
               pc_in = pcc_pkg::ST_CLEAR;
            end else if (req_step_time == '0) begin
               pc_in = pcc_pkg::ST_DONE;
            end else begin
               pc_in = uword.target;
            end
         end
         pcc_pkg::BR_LOOP: begin
            if (cnt_ff == pcc_pkg::LoopLast) begin
               cnt_in = '0;
               pc_in  = pcc_pkg::step_type'(pc_ff + 5'd1);
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         pcc_pkg::BR_WAIT: begin
            if (blocked) begin
               op = pcc_pkg::OP_NOP;
            end else begin
               pc_in        = uword.target;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            pc_in = pcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= pcc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_loop_count_only_in_divide: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (pc_ff == pcc_pkg::ST_DIV_STEP))
      else $error("divider loop count is running outside the divide step");

   a_done_raises_valid: assert property (@(posedge clock) disable iff (reset)
      (op == pcc_pkg::OP_DONE) |=> rsp_valid_ff)
      else $error("finished step did not present a response word");
`endif

endmodule

// File: src/pcc_datapath.sv
// Datapath of the clamped PID controller: gain registers, controller state, one shared
// multiplier, a restoring divider for the derivative and the response registers.
// Driven one operation a cycle by pcc_sequencer; depends on pcc_pkg.
module pcc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  pcc_pkg::op_type        op,
   input  logic                   csr_wr_en,
   input  pcc_pkg::csr_addr_type  csr_index,
   input  logic [31:0]            csr_wr_data,
   input  pcc_pkg::sample_type    req_target,
   input  pcc_pkg::sample_type    req_measured,
   input  pcc_pkg::step_time_type req_step_time,
   output pcc_pkg::sample_type    rsp_drive,
   output pcc_pkg::sample_type    rsp_integral_now
);

   pcc_pkg::sample_type    prop_gain_ff, prop_gain_in;
   pcc_pkg::sample_type    integ_gain_ff, integ_gain_in;
   pcc_pkg::sample_type    deriv_gain_ff, deriv_gain_in;
   pcc_pkg::bound_type     integral_bound_ff, integral_bound_in;
   pcc_pkg::bound_type     drive_bound_ff, drive_bound_in;
   pcc_pkg::sample_type    integ_ff, integ_in;
   pcc_pkg::sample_type    last_err_ff, last_err_in;
   pcc_pkg::sample_type    drive_ff, drive_in;
   pcc_pkg::sample_type    target_ff, target_in;
   pcc_pkg::sample_type    measured_ff, measured_in;
   pcc_pkg::step_time_type step_time_ff, step_time_in;
   pcc_pkg::sample_type    err_ff, err_in;
   pcc_pkg::sample_type    tmp_ff, tmp_in;
   pcc_pkg::sample_type    deriv_ff, deriv_in;
   pcc_pkg::acc_type       acc_ff, acc_in;
   pcc_pkg::wide_type      prod_ff, prod_in;
   logic [31:0]            rem_ff, rem_in;
   logic [31:0]            num_ff, num_in;
   logic                   neg_ff, neg_in;
   logic                   ovf_ff, ovf_in;
   pcc_pkg::sample_type    rsp_drive_ff, rsp_drive_in;
   pcc_pkg::sample_type    rsp_integ_ff, rsp_integ_in;

   pcc_pkg::mul_type       mul_a;
   pcc_pkg::mul_type       mul_b;
   pcc_pkg::wide_type      product;
   logic signed [32:0]     diff;
   logic [32:0]            diff_mag;
   logic [33:0]            trial;
   pcc_pkg::wide_type      quot_mag;
   pcc_pkg::wide_type      quot_signed;
   pcc_pkg::sample_type    term16;
   pcc_pkg::sample_type    term24;
   logic signed [33:0]     err_diff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op)
         pcc_pkg::OP_MUL_P: begin
            mul_a = {prop_gain_ff[31], prop_gain_ff};
            mul_b = {err_ff[31], err_ff};
         end
         pcc_pkg::OP_MUL_INC: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = {1'b0, step_time_ff};
         end
         pcc_pkg::OP_MUL_I: begin
            mul_a = {integ_gain_ff[31], integ_gain_ff};
            mul_b = {integ_ff[31], integ_ff};
         end
         pcc_pkg::OP_MUL_D: begin
            mul_a = {deriv_gain_ff[31], deriv_gain_ff};
            mul_b = {deriv_ff[31], deriv_ff};
         end
         default: begin
         end
      endcase
   end

   assign product     = mul_a * mul_b;
   assign term16      = pcc_pkg::sat(prod_ff >>> 16);
   assign term24      = pcc_pkg::sat(prod_ff >>> 24);
   assign diff        = {err_ff[31], err_ff} - {last_err_ff[31], last_err_ff};
   assign diff_mag    = diff[32] ? 33'(-diff) : 33'(diff);
   assign trial       = {1'b0, rem_ff, num_ff[31]} - {2'b00, step_time_ff};
   assign quot_mag    = ovf_ff ? (pcc_pkg::wide_type'(1) <<< 32)
                               : pcc_pkg::wide_type'({1'b0, num_ff});
   assign quot_signed = neg_ff ? -quot_mag : quot_mag;
   assign err_diff    = 34'(target_ff) - 34'(measured_ff);

   always_comb begin
      prop_gain_in      = prop_gain_ff;
      integ_gain_in     = integ_gain_ff;
      deriv_gain_in     = deriv_gain_ff;
      integral_bound_in = integral_bound_ff;
      drive_bound_in    = drive_bound_ff;
      integ_in          = integ_ff;
      last_err_in       = last_err_ff;
      drive_in          = drive_ff;
      target_in         = target_ff;
      measured_in       = measured_ff;
      step_time_in      = step_time_ff;
      err_in            = err_ff;
      tmp_in            = tmp_ff;
      deriv_in          = deriv_ff;
      acc_in            = acc_ff;
      prod_in           = prod_ff;
      rem_in            = rem_ff;
      num_in            = num_ff;
      neg_in            = neg_ff;
      ovf_in            = ovf_ff;
      rsp_drive_in      = rsp_drive_ff;
      rsp_integ_in      = rsp_integ_ff;

      if (csr_wr_en) begin
         unique case (pcc_pkg::csr_index_type'(csr_index))
            pcc_pkg::CSR_PROP_GAIN:      prop_gain_in      = csr_wr_data;
            pcc_pkg::CSR_INTEG_GAIN:     integ_gain_in     = csr_wr_data;
            pcc_pkg::CSR_DERIV_GAIN:     deriv_gain_in     = csr_wr_data;
            pcc_pkg::CSR_INTEGRAL_BOUND: integral_bound_in = csr_wr_data[30:0];
            pcc_pkg::CSR_DRIVE_BOUND:    drive_bound_in    = csr_wr_data[30:0];
            default: begin
            end
         endcase
      end

      unique case (op)
         pcc_pkg::OP_LOAD: begin
            target_in    = req_target;
            measured_in  = req_measured;
            step_time_in = req_step_time;
         end
         pcc_pkg::OP_CLEAR: begin
            integ_in    = '0;
            last_err_in = '0;
            drive_in    = '0;
         end
         pcc_pkg::OP_ERR: begin
            err_in = pcc_pkg::sat(pcc_pkg::wide_type'(err_diff));
         end
         pcc_pkg::OP_MUL_P, pcc_pkg::OP_MUL_INC, pcc_pkg::OP_MUL_I,
         pcc_pkg::OP_MUL_D: begin
            prod_in = product;
         end
         pcc_pkg::OP_ACC_P: begin
            acc_in = 34'(term16);
         end
         pcc_pkg::OP_INC: begin
            tmp_in = term24;
         end
         pcc_pkg::OP_ADD_I: begin
            tmp_in = pcc_pkg::sat(pcc_pkg::wide_type'(integ_ff) +
                                  pcc_pkg::wide_type'(tmp_ff));
         end
         pcc_pkg::OP_CLAMP_I: begin
            integ_in = pcc_pkg::clamp_mag(tmp_ff, integral_bound_ff);
         end
         pcc_pkg::OP_ACC_I, pcc_pkg::OP_ACC_D: begin
            acc_in = acc_ff + 34'(term16);
         end
         pcc_pkg::OP_DIV_INIT: begin
            neg_in = diff[32];
            rem_in = {8'b0, diff_mag[31:8]};
            num_in = {diff_mag[7:0], 24'b0};
            ovf_in = ({8'b0, diff_mag[31:8]} >= step_time_ff);
         end
         pcc_pkg::OP_DIV_STEP: begin
            if (trial[33]) begin
               rem_in = {rem_ff[30:0], num_ff[31]};
            end else begin
               rem_in = trial[31:0];
            end
            num_in = {num_ff[30:0], ~trial[33]};
         end
         pcc_pkg::OP_DIV_FIX: begin
            deriv_in = pcc_pkg::sat(quot_signed);
         end
         pcc_pkg::OP_DRIVE: begin
            drive_in    = pcc_pkg::clamp_mag(pcc_pkg::sat(pcc_pkg::wide_type'(acc_ff)),
                                             drive_bound_ff);
            last_err_in = err_ff;
         end
         pcc_pkg::OP_DONE: begin
            rsp_drive_in = drive_ff;
            rsp_integ_in = integ_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff      <= '0;
         integ_gain_ff     <= '0;
         deriv_gain_ff     <= '0;
         integral_bound_ff <= '0;
         drive_bound_ff    <= '0;
         integ_ff          <= '0;
         last_err_ff       <= '0;
         drive_ff          <= '0;
      end else begin
         prop_gain_ff      <= prop_gain_in;
         integ_gain_ff     <= integ_gain_in;
         deriv_gain_ff     <= deriv_gain_in;
         integral_bound_ff <= integral_bound_in;
         drive_bound_ff    <= drive_bound_in;
         integ_ff          <= integ_in;
         last_err_ff       <= last_err_in;
         drive_ff          <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      measured_ff  <= measured_in;
      step_time_ff <= step_time_in;
      err_ff       <= err_in;
      tmp_ff       <= tmp_in;
      deriv_ff     <= deriv_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      neg_ff       <= neg_in;
      ovf_ff       <= ovf_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_integ_ff <= rsp_integ_in;
   end

   assign rsp_drive        = rsp_drive_ff;
   assign rsp_integral_now = rsp_integ_ff;

`ifndef SYNTHESIS
   a_integral_within_bound: assert property (@(posedge clock) disable iff (reset)
      (op == pcc_pkg::OP_CLAMP_I) |=>
         ($signed({integ_ff[31], integ_ff}) <= $signed({2'b00, integral_bound_ff})) &&
         ($signed({integ_ff[31], integ_ff}) >= -$signed({2'b00, integral_bound_ff})))
      else $error("error integral left its bound after clamping");

   a_drive_within_bound: assert property (@(posedge clock) disable iff (reset)
      (op == pcc_pkg::OP_DRIVE) |=>
         ($signed({drive_ff[31], drive_ff}) <= $signed({2'b00, drive_bound_ff})) &&
         ($signed({drive_ff[31], drive_ff}) >= -$signed({2'b00, drive_bound_ff})))
      else $error("controller output left its bound after clamping");
`endif

endmodule

// File: src/pid_clamped_controller_unit.sv
// A run step with non-zero step time runs the full microcode sequence before its response
// word is valid; the next request word is taken only in the idle step. A clear runs the
// clear and done steps, a zero step time only the done step. A run step's length is set
// mainly by the 32 iterations of the restoring divider for the derivative and by the one
// shared 33 by 33 bit multiplier that serves all products in turn. A finished response
// word is held in its own register, so a new request word is accepted while it waits.
// Top level of the clamped PID controller; depends on pcc_pkg, the channel interfaces,
// pcc_sequencer and pcc_datapath.
module pid_clamped_controller_unit (
   input  logic                  clock,
   input  logic                  reset,
   pcc_req_if.sink               req_if,
   pcc_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  pcc_pkg::csr_addr_type csr_index,
   input  logic [31:0]           csr_wr_data
);

   pcc_pkg::op_type op;

   pcc_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_action    (req_if.action),
      .req_step_time (req_if.step_time),
      .req_ready     (req_if.ready),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .op            (op)
   );

   pcc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_target       (req_if.target),
      .req_measured     (req_if.measured),
      .req_step_time    (req_if.step_time),
      .rsp_drive        (rsp_if.drive),
      .rsp_integral_now (rsp_if.integral_now)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request word accepted while a step was still running");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the clamped PID controller: random and directed request words,
// checked field by field against a predictor of the control law kept inside this file.
// Depends on pcc_pkg, the channel interfaces and pid_clamped_controller_unit.
module tb;

   typedef enum logic {
      ACT_STEP  = 1'b0,
      ACT_CLEAR = 1'b1
   } action_type;

   typedef struct packed {
      action_type             action;
      pcc_pkg::sample_type    target;
      pcc_pkg::sample_type    measured;
      pcc_pkg::step_time_type step_time;
   } pid_request_type;

   typedef struct packed {
      pcc_pkg::sample_type drive;
      pcc_pkg::sample_type integral_now;
   } pid_output_type;

   localparam pcc_pkg::csr_addr_type CsrFirstUnmapped = 3'd5;
   localparam longint SampleMax = 64'sd2147483647;
   localparam longint SampleMin = -64'sd2147483648;
   localparam int QOne = 65536;
   localparam int HoldOffCycles = 400;
   localparam int WordsPerSegment = 330;
   localparam int SegmentCount = 6;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   pcc_pkg::csr_addr_type csr_index;
   logic [31:0]           csr_wr_data;

   pcc_req_if req_ch();
   pcc_rsp_if rsp_ch();

   pid_clamped_controller_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   longint kp_gain = 0;
   longint ki_gain = 0;
   longint kd_gain = 0;
   longint integ_limit = 0;
   longint drive_limit = 0;
   longint integ_acc = 0;
   longint prev_error = 0;
   longint prev_drive = 0;

   pid_request_type     setpoint_queue[$];
   pid_output_type      predicted_outputs[$];
   pid_request_type     next_word;
   pid_request_type     taken_word;
   pid_output_type      head_output;
   pcc_pkg::sample_type setpoint = '0;
   int                  error_count = 0;
   int                  tx_idle_pct = 22;
   int                  rx_idle_pct = 76;
   int                  hold_left = 0;
   bit                  hold_done = 1'b0;
   bit                  req_accepted = 1'b0;

   function automatic longint saturate(input longint x);
      if (x > SampleMax) begin
         return SampleMax;
      end
      if (x < SampleMin) begin
         return SampleMin;
      end
      return x;
   endfunction

   function automatic longint limit_mag(input longint x, input longint b);
      if (x > b) begin
         return b;
      end
      if (x < -b) begin
         return -b;
      end
      return x;
   endfunction

   function automatic pid_output_type pid_update(input pid_request_type w);
      longint dt;
      longint err;
      longint incr;
      longint p_term;
      longint i_term;
      longint deriv;
      longint d_term;
      pid_output_type r;
      dt = longint'({32'd0, w.step_time});
      if (w.action == ACT_CLEAR) begin
         integ_acc = 0;
         prev_error = 0;
         prev_drive = 0;
      end else if (dt != 0) begin
         err = saturate(longint'($signed(w.target)) - longint'($signed(w.measured)));
         p_term = saturate((kp_gain * err) >>> 16);
         incr = saturate((err * dt) >>> 24);
         integ_acc = limit_mag(saturate(integ_acc + incr), integ_limit);
         i_term = saturate((ki_gain * integ_acc) >>> 16);
         deriv = saturate(((err - prev_error) * 64'sd16777216) / dt);
         d_term = saturate((kd_gain * deriv) >>> 16);
         prev_drive = limit_mag(saturate(p_term + i_term + d_term), drive_limit);
         prev_error = err;
      end
      r.drive = prev_drive[31:0];
      r.integral_now = integ_acc[31:0];
      return r;
   endfunction

   function automatic void queue_word(input action_type a, input logic [31:0] t,
                                      input logic [31:0] m, input logic [31:0] dt);
      pid_request_type w;
      w = '{a, t, m, dt};
      setpoint_queue.push_back(w);
   endfunction

   function automatic logic [31:0] random_gain();
      if ($urandom_range(1) == 0) begin
         return $urandom_range(0, 1 << 19) - (1 << 18);
      end
      return $urandom();
   endfunction

   function automatic logic [31:0] random_bound();
      case ($urandom_range(3))
         0: return '0;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 1 << 24);
         default: return $urandom();
      endcase
   endfunction

   // Most words follow a slowly moving setpoint so that the integral builds up and clamps.
   function automatic pid_request_type random_request();
      pid_request_type w;
      w.action = ($urandom_range(99) < 4) ? ACT_CLEAR : ACT_STEP;
      if ($urandom_range(9) == 0) begin
         setpoint = $urandom_range(0, 1 << 24) - (1 << 23);
      end
      case ($urandom_range(9))
         0, 1: begin
            w.target = $urandom();
            w.measured = $urandom();
         end
         2: begin
            w.target = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            w.measured = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         end
         default: begin
            w.target = setpoint;
            w.measured = setpoint + $urandom_range(0, 1 << 18) - (1 << 17);
         end
      endcase
      case ($urandom_range(19))
         0: w.step_time = '0;
         1: w.step_time = $urandom_range(1, 255);
         2, 3, 4: w.step_time = $urandom();
         default: w.step_time = $urandom_range(1, 1 << 24);
      endcase
      return w;
   endfunction

   task automatic write_register(input pcc_pkg::csr_addr_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      case (idx)
         pcc_pkg::CSR_PROP_GAIN:      kp_gain = longint'($signed(data));
         pcc_pkg::CSR_INTEG_GAIN:     ki_gain = longint'($signed(data));
         pcc_pkg::CSR_DERIV_GAIN:     kd_gain = longint'($signed(data));
         pcc_pkg::CSR_INTEGRAL_BOUND: integ_limit = longint'({33'd0, data[30:0]});
         pcc_pkg::CSR_DRIVE_BOUND:    drive_limit = longint'({33'd0, data[30:0]});
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki,
                            input logic [31:0] kd, input logic [31:0] ib,
                            input logic [31:0] db);
      write_register(pcc_pkg::CSR_PROP_GAIN, kp);
      write_register(pcc_pkg::CSR_INTEG_GAIN, ki);
      write_register(pcc_pkg::CSR_DERIV_GAIN, kd);
      write_register(pcc_pkg::CSR_INTEGRAL_BOUND, ib);
      write_register(pcc_pkg::CSR_DRIVE_BOUND, db);
   endtask

   task automatic wait_drained();
      while (setpoint_queue.size() != 0 || req_ch.valid || predicted_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_accepted) begin
         if (setpoint_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            next_word = setpoint_queue.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.action <= next_word.action;
            req_ch.target <= next_word.target;
            req_ch.measured <= next_word.measured;
            req_ch.step_time <= next_word.step_time;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Once idling stops, the receiver holds off long enough for the block to fill and stall.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && tx_idle_pct == 0 && rx_idle_pct == 0 && rsp_ch.valid) begin
         hold_done <= 1'b1;
         hold_left <= HoldOffCycles;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      req_accepted <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (predicted_outputs.size() == 0) begin
            $error("response word with none expected: drive %0d, integral_now %0d",
                   $signed(rsp_ch.drive), $signed(rsp_ch.integral_now));
            error_count++;
         end else begin
            head_output = predicted_outputs.pop_front();
            if (rsp_ch.drive !== head_output.drive) begin
               $error("drive: expected %0d, got %0d",
                      $signed(head_output.drive), $signed(rsp_ch.drive));
               error_count++;
            end
            if (rsp_ch.integral_now !== head_output.integral_now) begin
               $error("integral_now: expected %0d, got %0d",
                      $signed(head_output.integral_now), $signed(rsp_ch.integral_now));
               error_count++;
            end
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         taken_word = '{action_type'(req_ch.action), req_ch.target, req_ch.measured,
                        req_ch.step_time};
         predicted_outputs.push_back(pid_update(taken_word));
      end
   end

   initial begin
      int seg;
      int n;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      queue_word(ACT_STEP, 5 * QOne, QOne, 32'h0100_0000);
      queue_word(ACT_CLEAR, 0, 0, 0);
      wait_drained();

      set_gains(2 * QOne, QOne / 2, 6554, 10 * QOne, 100 * QOne);
      for (n = int'(CsrFirstUnmapped); n < (1 << $bits(pcc_pkg::csr_addr_type)); n++) begin
         write_register(pcc_pkg::csr_addr_type'(n), $urandom());
      end
      queue_word(ACT_STEP, QOne, 0, 167772);
      queue_word(ACT_STEP, QOne, 0, 167772);
      queue_word(ACT_STEP, 3 * QOne, 0, 0);
      queue_word(ACT_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_word(ACT_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 1);
      queue_word(ACT_STEP, 0, 0, 1);
      queue_word(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_word(ACT_STEP, 0, 0, 0);
      queue_word(ACT_STEP, -QOne, 2 * QOne, 32'h0100_0000);
      queue_word(ACT_STEP, 32'h4000_0000, 32'h4000_0000, 32'hFFFF_FFFF);
      for (n = 0; n < 6; n++) begin
         queue_word(ACT_STEP, 50 * QOne, 0, 32'h0100_0000);
      end
      queue_word(ACT_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_word(ACT_STEP, 32'h8000_0000, 0, 32'h0000_0100);
      wait_drained();

      for (seg = 0; seg < SegmentCount; seg++) begin
         case (seg)
            1: set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF);
            2: set_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
            5: set_gains(random_gain(), random_gain(), random_gain(),
                         32'h7FFF_FFFF, 32'hFFFF_FFFF);
            default: set_gains(random_gain(), random_gain(), random_gain(),
                               random_bound(), random_bound());
         endcase
         case (seg / 2)
            0: begin
               tx_idle_pct = 22;
               rx_idle_pct = 76;
            end
            1: begin
               tx_idle_pct = 76;
               rx_idle_pct = 22;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (n = 0; n < WordsPerSegment; n++) begin
            setpoint_queue.push_back(random_request());
         end
         wait_drained();
      end

      repeat (60) @(negedge clock);
      if (error_count == 0 && predicted_outputs.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
